[hw/rtl/sled_pkg.sv]
package sled_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int CMDQ_DEPTH      = 2;

    localparam logic [1:0] MODE_RX    = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_UNGET = 2'd2;

    localparam logic [1:0] KIND_ECHO    = 2'd0;
    localparam logic [1:0] KIND_DELIVER = 2'd1;
    localparam logic [1:0] KIND_REFUSE  = 2'd2;

    localparam logic [7:0] BYTE_BS   = 8'h08;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] BYTE_SP   = 8'h20;
    localparam logic [7:0] CHAR_MASK = 8'h7F;

    typedef enum logic [2:0] {
        OP_REFUSE,
        OP_ECHO,
        OP_RUBOUT,
        OP_NEWLINE,
        OP_ECHO_DELIV,
        OP_DELIV
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] echo_byte;
        logic [7:0] deliv_byte;
    } cmd_t;

    function automatic logic [1:0] op_len(input op_t op);
        logic [1:0] n;
        case (op)
            OP_RUBOUT:     n = 2'd3;
            OP_NEWLINE:    n = 2'd3;
            OP_ECHO_DELIV: n = 2'd2;
            default:       n = 2'd1;
        endcase
        return n;
    endfunction

endpackage

[hw/rtl/sled_front.sv]
module sled_front #(
    parameter int Depth = sled_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic [7:0]        in_byte,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output sled_pkg::cmd_t    cmd
);

    localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);
    localparam logic [CntW:0]   DepthW  = (CntW + 1)'(Depth);

    logic [7:0] mem [Depth];

    logic [IdxW-1:0] front_reg, front_next;
    logic [CntW-1:0] fill_reg, fill_next;
    logic            coll_reg, coll_next;
    logic            s1_valid_reg, s1_valid_next;
    sled_pkg::op_t   s1_op_reg, s1_op_next;
    logic [7:0]      s1_echo_reg;
    logic            s1_direct_reg, s1_direct_next;
    logic [7:0]      rd_data_reg;

    logic            accept;
    logic            emit;
    logic [7:0]      masked;
    logic [CntW:0]   tail_sum;
    logic [IdxW-1:0] tail_idx;
    logic [IdxW-1:0] front_inc;
    logic [IdxW-1:0] front_dec;
    logic [CntW-1:0] fill_inc;
    logic [CntW-1:0] fill_dec;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    logic [7:0]      wr_data;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !s1_valid_reg || cmd_ready;
    assign cmd_valid = s1_valid_reg;
    assign cmd.op         = s1_op_reg;
    assign cmd.echo_byte  = s1_echo_reg;
    assign cmd.deliv_byte = s1_direct_reg ? sled_pkg::BYTE_CR : rd_data_reg;

    assign masked    = in_byte & sled_pkg::CHAR_MASK;
    assign tail_sum  = (CntW + 1)'(front_reg) + (CntW + 1)'(fill_reg);
    assign tail_idx  = (tail_sum >= DepthW) ? IdxW'(tail_sum - DepthW) : IdxW'(tail_sum);
    assign front_inc = (front_reg == LastIdx) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LastIdx : front_reg - 1'b1;
    assign fill_inc  = fill_reg + 1'b1;
    assign fill_dec  = fill_reg - 1'b1;

    always_comb
    begin
        front_next     = front_reg;
        fill_next      = fill_reg;
        coll_next      = coll_reg;
        wr_en          = 1'b0;
        wr_addr        = tail_idx;
        wr_data        = masked;
        emit           = 1'b0;
        s1_op_next     = sled_pkg::OP_REFUSE;
        s1_direct_next = 1'b0;
        if (accept)
        begin
            emit = 1'b1;
            case (mode)
                sled_pkg::MODE_RX:
                begin
                    if (!coll_reg)
                    begin
                        s1_op_next = sled_pkg::OP_REFUSE;
                    end
                    else if (masked == sled_pkg::BYTE_BS)
                    begin
                        if (fill_reg == '0)
                        begin
                            emit = 1'b0;
                        end
                        else
                        begin
                            s1_op_next = sled_pkg::OP_RUBOUT;
                            fill_next  = fill_dec;
                        end
                    end
                    else if (masked == sled_pkg::BYTE_CR)
                    begin
                        wr_en          = 1'b1;
                        coll_next      = 1'b0;
                        front_next     = front_inc;
                        s1_op_next     = sled_pkg::OP_NEWLINE;
                        s1_direct_next = (fill_reg == '0);
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        if (fill_inc == FullCnt)
                        begin
                            coll_next  = 1'b0;
                            front_next = front_inc;
                            s1_op_next = sled_pkg::OP_ECHO_DELIV;
                        end
                        else
                        begin
                            fill_next  = fill_inc;
                            s1_op_next = sled_pkg::OP_ECHO;
                        end
                    end
                end
                sled_pkg::MODE_READ:
                begin
                    if (coll_reg)
                    begin
                        s1_op_next = sled_pkg::OP_REFUSE;
                    end
                    else if (fill_reg == '0)
                    begin
                        coll_next = 1'b1;
                        emit      = 1'b0;
                    end
                    else
                    begin
                        s1_op_next = sled_pkg::OP_DELIV;
                        front_next = front_inc;
                        fill_next  = fill_dec;
                    end
                end
                sled_pkg::MODE_UNGET:
                begin
                    if (coll_reg || (fill_reg == FullCnt))
                    begin
                        s1_op_next = sled_pkg::OP_REFUSE;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = front_dec;
                        wr_data    = in_byte;
                        front_next = front_dec;
                        fill_next  = fill_inc;
                        emit       = 1'b0;
                    end
                end
                default:
                begin
                    s1_op_next = sled_pkg::OP_REFUSE;
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd_ready)
        begin
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg    <= '0;
            fill_reg     <= '0;
            coll_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg    <= front_next;
            fill_reg     <= fill_next;
            coll_reg     <= coll_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg     <= s1_op_next;
            s1_echo_reg   <= masked;
            s1_direct_reg <= s1_direct_next;
        end
    end

    // read and write one port each; a same-address hit is served by the direct flag
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (accept)
        begin
            rd_data_reg <= mem[front_reg];
        end
    end

endmodule

[hw/rtl/sled_cmdq.sv]
module sled_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  sled_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output sled_pkg::cmd_t pop_data
);

    localparam int PtrW = (sled_pkg::CMDQ_DEPTH > 1) ? $clog2(sled_pkg::CMDQ_DEPTH) : 1;
    localparam int CntW = $clog2(sled_pkg::CMDQ_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(sled_pkg::CMDQ_DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(sled_pkg::CMDQ_DEPTH);

    sled_pkg::cmd_t  entry_reg [sled_pkg::CMDQ_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (cnt_reg != FullCnt);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/sled_back.sv]
module sled_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  sled_pkg::cmd_t cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     out_kind,
    output logic [7:0]     out_byte,
    output logic           is_last
);

    logic [1:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_kind_reg, out_kind_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       is_last_reg;
    logic       load;
    logic       last;

    assign load      = cmd_valid && (!out_valid_reg || out_ready);
    assign last      = (step_reg == (sled_pkg::op_len(cmd.op) - 2'd1));
    assign cmd_ready = load && last;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign is_last   = is_last_reg;

    always_comb
    begin
        out_kind_next = sled_pkg::KIND_ECHO;
        out_byte_next = cmd.echo_byte;
        case (cmd.op)
            sled_pkg::OP_REFUSE:
            begin
                out_kind_next = sled_pkg::KIND_REFUSE;
                out_byte_next = '0;
            end
            sled_pkg::OP_ECHO:
            begin
                out_byte_next = cmd.echo_byte;
            end
            sled_pkg::OP_RUBOUT:
            begin
                out_byte_next = (step_reg == 2'd1) ? sled_pkg::BYTE_SP : sled_pkg::BYTE_BS;
            end
            sled_pkg::OP_NEWLINE:
            begin
                case (step_reg)
                    2'd0:    out_byte_next = sled_pkg::BYTE_CR;
                    2'd1:    out_byte_next = sled_pkg::BYTE_LF;
                    default:
                    begin
                        out_kind_next = sled_pkg::KIND_DELIVER;
                        out_byte_next = cmd.deliv_byte;
                    end
                endcase
            end
            sled_pkg::OP_ECHO_DELIV:
            begin
                if (step_reg != 2'd0)
                begin
                    out_kind_next = sled_pkg::KIND_DELIVER;
                    out_byte_next = cmd.deliv_byte;
                end
            end
            sled_pkg::OP_DELIV:
            begin
                out_kind_next = sled_pkg::KIND_DELIVER;
                out_byte_next = cmd.deliv_byte;
            end
            default:
            begin
                out_kind_next = sled_pkg::KIND_REFUSE;
                out_byte_next = '0;
            end
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            step_next      = last ? 2'd0 : step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_kind_reg <= out_kind_next;
            out_byte_reg <= out_byte_next;
            is_last_reg  <= last;
        end
    end

endmodule

[hw/rtl/serial_line_editor_queue.sv]
// Path: the first result of an item passes through the classify register (it loads on the
// accepting edge), then the command queue, then the output register; later results of the
// same item follow one per cycle while out_ready is held high.
// Throughput: one item per cycle on input while the command queue takes commands; output
// drains one result per cycle while out_ready is high, and an item yields 0 to 3 results.
// Reset: rst_n is asynchronous; it empties the line queue, the command queue and the
// output register and leaves the block not collecting. Stored characters are not cleared.
module serial_line_editor_queue #(
    parameter int QUEUE_DEPTH = sled_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] out_kind,
    output logic [7:0] out_byte,
    output logic       is_last
);

    logic           front_cmd_valid;
    logic           front_cmd_ready;
    sled_pkg::cmd_t front_cmd;
    logic           back_cmd_valid;
    logic           back_cmd_ready;
    sled_pkg::cmd_t back_cmd;

    sled_front #(
        .Depth(QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .in_byte   (in_byte),
        .cmd_valid (front_cmd_valid),
        .cmd_ready (front_cmd_ready),
        .cmd       (front_cmd)
    );

    sled_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_cmd_valid),
        .push_ready (front_cmd_ready),
        .push_data  (front_cmd),
        .pop_valid  (back_cmd_valid),
        .pop_ready  (back_cmd_ready),
        .pop_data   (back_cmd)
    );

    sled_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_cmd_valid),
        .cmd_ready (back_cmd_ready),
        .cmd       (back_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .is_last   (is_last)
    );

`ifndef SYNTH
    a_refuse_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_kind == sled_pkg::KIND_REFUSE)) |-> (is_last && (out_byte == 8'd0)))
        else $error("refusal not a single zero result");

    a_deliver_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_kind == sled_pkg::KIND_DELIVER)) |-> is_last)
        else $error("delivered character not the final result");

    a_echo_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_kind == sled_pkg::KIND_ECHO)) |-> (!out_byte[7] && !is_last) ||
        (!out_byte[7]))
        else $error("echo byte has bit 7 set");

    a_cmd_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (back_cmd_valid && back_cmd_ready) |-> (out_valid == 1'b0 || out_ready))
        else $error("command retired while output stalled");
`endif

endmodule
